// ----- rtl/core/afmt_pkg.sv -----
// Shared types, constants and helpers for the affine matrix transform engine.
// Used by afmt_lane, afmt_merge and affine_matrix_transform_engine.
`default_nettype none

package afmt_pkg;

   // Fixed-point format: signed Q(32-FRAC_BITS).FRAC_BITS words
   localparam int FRAC_BITS = 16;
   localparam int WORD_W    = 32;
   localparam int LANES     = 4;               // one lane per matrix row
   localparam int ELEMS     = LANES * LANES;
   localparam int IDX_W     = $clog2(ELEMS);
   localparam int PSH_W     = 2 * WORD_W - FRAC_BITS;   // shifted product width
   localparam int SUM_W     = PSH_W + 2;                // sum of four products
   // Unity in fixed point: multiplying by it passes an element through unchanged
   localparam logic [WORD_W-1:0] FX_ONE = WORD_W'(1) << FRAC_BITS;

   typedef enum logic [2:0] {
      CMD_LOAD      = 3'd0,
      CMD_VECTOR    = 3'd1,
      CMD_POINT     = 3'd2,
      CMD_TRANSLATE = 3'd3,
      CMD_SCALE     = 3'd4
   } cmd_type;

   typedef struct packed {
      logic              flag;
      logic [WORD_W-1:0] val;
   } sat_type;

   // What one row lane hands on after its sum stage
   typedef struct packed {
      logic [WORD_W-1:0]       sum;      // saturated row sum
      logic                    sum_sat;  // row sum clipped
      logic [2:0][WORD_W-1:0]  scl;      // saturated single products, columns 0..2
   } lane_res_type;

   // Clip a wide signed value to the 32-bit signed range
   function automatic sat_type sat_word(input logic [SUM_W-1:0] v);
      sat_type                   r;
      logic [SUM_W-WORD_W:0]     hi;
      hi = v[SUM_W-1:WORD_W-1];
      if ((&hi) || !(|hi)) begin
         r.flag = 1'b0;
         r.val  = v[WORD_W-1:0];
      end else begin
         r.flag = 1'b1;
         r.val  = v[SUM_W-1] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/affine_matrix_transform_engine.sv -----
// Top level of the affine matrix transform engine: matrix registers, lanes, control.
// Depends on afmt_pkg, afmt_lane and afmt_merge.
`default_nettype none

// Holds a 4x4 column-major Q16.16 matrix (cleared at reset) and runs one command word per
// cycle when nothing stalls. Four row lanes each form four 32x32 products in the cycle a
// word is taken and sum and saturate them in the next; a result goes from the sum stage
// into the output register once that register is free. Loads and transforms go at one
// word per cycle when nothing stalls. Translate and scale write the matrix back from the
// sum stage, so no word is taken while they are there. The output register decouples the
// sides; when it is full and not taken, a transform in the sum stage holds and input stalls.
module affine_matrix_transform_engine
   import afmt_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [167:0]  req_tdata,   // elem_index, elem_value, vec_x, vec_y, vec_z, vec_w
   input  wire logic [2:0]    req_tuser,   // cmd
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [127:0]       rsp_tdata,   // out_x, out_y, out_z, out_w
   output logic [0:0]         rsp_tuser    // saturated
);

   logic                     req_acc;
   cmd_type                  req_cmd;
   logic [IDX_W-1:0]         req_idx;
   logic [WORD_W-1:0]        req_val;
   logic signed [WORD_W-1:0] req_vec [LANES];

   logic [WORD_W-1:0]        matrix_ff [ELEMS];
   logic [WORD_W-1:0]        matrix_in [ELEMS];
   logic signed [WORD_W-1:0] row_elem [LANES][LANES];

   logic                     s1_valid_ff, s1_valid_in;
   cmd_type                  s1_cmd_ff, s1_cmd_in;
   logic                     s1_has_rsp, s1_move, out_free;
   lane_res_type             lane_res [LANES];

   // Field unpacking
   assign req_cmd = cmd_type'(req_tuser);
   assign req_idx = req_tdata[3:0];
   assign req_val = req_tdata[35:4];
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         req_vec[i] = $signed(req_tdata[36 + i*WORD_W +: WORD_W]);
      end
   end

   // Handshake: matrix updates in the sum stage block the next word, as does a transform held by a full output
   assign s1_has_rsp = (s1_cmd_ff == CMD_VECTOR) || (s1_cmd_ff == CMD_POINT);
   assign out_free   = !rsp_tvalid || rsp_tready;
   assign s1_move    = s1_valid_ff && (!s1_has_rsp || out_free);
   assign req_tready = !s1_valid_ff || (s1_has_rsp && out_free);
   assign req_acc    = req_tvalid && req_tready;

   // Sum stage tracking
   always_comb begin
      s1_cmd_in   = s1_cmd_ff;
      s1_valid_in = s1_valid_ff;
      if (req_acc) begin
         s1_cmd_in   = req_cmd;
         s1_valid_in = (req_cmd == CMD_VECTOR) || (req_cmd == CMD_POINT) ||
                       (req_cmd == CMD_TRANSLATE) || (req_cmd == CMD_SCALE);
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_cmd_ff   <= CMD_LOAD;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s1_cmd_ff   <= s1_cmd_in;
      end
   end

   // Matrix update: element loads at accept, translate and scale from the sum stage
   always_comb begin
      matrix_in = matrix_ff;
      if (req_acc && (req_cmd == CMD_LOAD)) begin
         matrix_in[req_idx] = req_val;
      end
      if (s1_valid_ff && (s1_cmd_ff == CMD_TRANSLATE)) begin
         for (int r = 0; r < LANES; r++) begin
            matrix_in[(LANES-1)*LANES + r] = lane_res[r].sum;
         end
      end
      if (s1_valid_ff && (s1_cmd_ff == CMD_SCALE)) begin
         for (int r = 0; r < LANES; r++) begin
            for (int c = 0; c < 3; c++) begin
               matrix_in[c*LANES + r] = lane_res[r].scl[c];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ELEMS; i++) begin
            matrix_ff[i] <= '0;
         end
      end else begin
         matrix_ff <= matrix_in;
      end
   end

   // Row lanes
   always_comb begin
      for (int r = 0; r < LANES; r++) begin
         for (int c = 0; c < LANES; c++) begin
            row_elem[r][c] = $signed(matrix_ff[c*LANES + r]);
         end
      end
   end

   for (genvar r = 0; r < LANES; r++) begin : g_lane
      afmt_lane u_lane (
         .clock     (clock),
         .capture   (req_acc),
         .is_vector (req_cmd == CMD_VECTOR),
         .elem      (row_elem[r]),
         .vec       (req_vec),
         .res       (lane_res[r])
      );
   end

   afmt_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .load       (s1_valid_ff && s1_has_rsp && out_free),
      .is_point   (s1_cmd_ff == CMD_POINT),
      .lane_res   (lane_res),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

`ifndef SYNTHESIS
   // A matrix update is never overtaken by the next word
   a_update_gap: assert property (@(posedge clock) disable iff (reset)
      (req_acc && ((req_cmd == CMD_TRANSLATE) || (req_cmd == CMD_SCALE))) |=> !req_acc)
      else $error("word accepted behind a matrix update");

   // A new result only comes from a transform in the sum stage
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(s1_valid_ff && s1_has_rsp))
      else $error("result appeared without a transform");

   // A transform waiting on a full output keeps its place
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_has_rsp && rsp_tvalid && !rsp_tready) |=>
      (s1_valid_ff && $stable(s1_cmd_ff)))
      else $error("sum stage lost a pending transform");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/afmt_lane.sv -----
// One row lane: four signed multipliers registered, then sum and saturate.
// Depends on afmt_pkg.
`default_nettype none

module afmt_lane
   import afmt_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     capture,
   input  wire logic                     is_vector,
   input  wire logic signed [WORD_W-1:0] elem [LANES],   // row elements, columns 0..3
   input  wire logic signed [WORD_W-1:0] vec  [LANES],   // x, y, z, w
   output lane_res_type                  res
);

   logic signed [WORD_W-1:0]   oper [LANES];
   logic signed [2*WORD_W-1:0] full [LANES];
   logic [PSH_W-1:0]           prod_in [LANES];
   logic [PSH_W-1:0]           prod_ff [LANES];
   logic [SUM_W-1:0]           sum;
   sat_type                    sum_s;
   sat_type                    scl_s [3];

   // Multiply stage; column 3 takes w for vectors, unity otherwise
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         oper[i] = vec[i];
      end
      if (!is_vector) begin
         oper[LANES-1] = $signed(FX_ONE);
      end
      for (int i = 0; i < LANES; i++) begin
         full[i]    = elem[i] * oper[i];
         prod_in[i] = full[i][2*WORD_W-1:FRAC_BITS];   // floor shift
      end
   end

   always_ff @(posedge clock) begin
      if (capture) begin
         prod_ff <= prod_in;
      end
   end

   // Sum stage and per-product clip for scaling
   always_comb begin
      sum = '0;
      for (int i = 0; i < LANES; i++) begin
         sum = sum + {{(SUM_W-PSH_W){prod_ff[i][PSH_W-1]}}, prod_ff[i]};
      end
      sum_s = sat_word(sum);
      for (int c = 0; c < 3; c++) begin
         scl_s[c] = sat_word({{(SUM_W-PSH_W){prod_ff[c][PSH_W-1]}}, prod_ff[c]});
      end
      res.sum     = sum_s.val;
      res.sum_sat = sum_s.flag;
      for (int c = 0; c < 3; c++) begin
         res.scl[c] = scl_s[c].val;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/afmt_merge.sv -----
// Output stage: gathers the four row lanes into one result word and flag.
// Depends on afmt_pkg.
`default_nettype none

module afmt_merge
   import afmt_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   load,
   input  wire logic                   is_point,
   input  wire lane_res_type           lane_res [LANES],
   input  wire logic                   rsp_tready,
   output logic                        rsp_tvalid,
   output logic [LANES*WORD_W-1:0]     rsp_tdata,   // out_x, out_y, out_z, out_w
   output logic [0:0]                  rsp_tuser    // saturated
);

   logic                       valid_ff, valid_in;
   logic [LANES*WORD_W-1:0]    data_ff, data_in;
   logic                       sat_ff, sat_in;

   // Pack rows; point transforms report w as zero but keep its flag
   always_comb begin
      sat_in = 1'b0;
      for (int r = 0; r < LANES; r++) begin
         data_in[r*WORD_W +: WORD_W] = lane_res[r].sum;
         sat_in = sat_in | lane_res[r].sum_sat;
      end
      if (is_point) begin
         data_in[(LANES-1)*WORD_W +: WORD_W] = '0;
      end
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
         sat_ff  <= sat_in;
      end
   end

   assign rsp_tvalid   = valid_ff;
   assign rsp_tdata    = data_ff;
   assign rsp_tuser[0] = sat_ff;

endmodule

`default_nettype wire

// ----- verif/affine_matrix_transform_checker.sv -----
// Checker for the affine matrix transform engine: tracks the matrix from the accepted
// command words, predicts every result word and compares it field by field.
// Depends on afmt_pkg (cmd_type codes, FRAC_BITS, ELEMS).
module affine_matrix_transform_checker
   import afmt_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   input  wire logic         req_tready,
   input  wire logic [167:0] req_tdata,   // elem_index, elem_value, vec_x, vec_y, vec_z, vec_w
   input  wire logic [2:0]   req_tuser,   // cmd
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [127:0] rsp_tdata,   // out_x, out_y, out_z, out_w
   input  wire logic [0:0]   rsp_tuser,   // saturated
   output int                fail_count,
   output int                pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint WORD_MAX = (longint'(1) <<< 31) - 1;
   localparam longint WORD_MIN = -(longint'(1) <<< 31);

   typedef struct {
      logic [31:0] x, y, z, w;
      logic        sat;
   } vertex_type;

   logic signed [31:0] model_matrix [ELEMS];
   vertex_type         expected_vertices [$];

   // Exact 64-bit product, arithmetic shift floors toward minus infinity
   function automatic longint fx_product(input logic signed [31:0] a,
                                         input logic signed [31:0] b);
      longint p;
      p = longint'(a) * longint'(b);
      return p >>> FRAC_BITS;
   endfunction

   // Clip to the signed 32-bit range; bit 32 tells that clipping happened
   function automatic logic [32:0] clip_word(input longint v);
      if (v > WORD_MAX) return {1'b1, 32'h7fffffff};
      if (v < WORD_MIN) return {1'b1, 32'h80000000};
      return {1'b0, v[31:0]};
   endfunction

   // Row r of M * (x, y, z), columns 0..2 only
   function automatic longint row_sum(input int r, input logic signed [31:0] x,
                                      input logic signed [31:0] y,
                                      input logic signed [31:0] z);
      return fx_product(model_matrix[r], x) + fx_product(model_matrix[4 + r], y)
           + fx_product(model_matrix[8 + r], z);
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %h, got %h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : monitor
      logic [2:0]         op;
      logic [3:0]         idx;
      logic signed [31:0] val, x, y, z, w;
      logic [31:0]        row_out [4];
      logic [32:0]        c;
      logic               flag;
      longint             s;
      vertex_type         v;
      if (reset) begin
         foreach (model_matrix[i]) model_matrix[i] = '0;
         expected_vertices.delete();
         fail_count = 0;
      end else begin
         // result side first: a word taken at this edge cannot answer itself
         if (rsp_tvalid && rsp_tready) begin
            if (expected_vertices.size() == 0) begin
               $error("result word with none expected: %h sat %b", rsp_tdata, rsp_tuser);
               fail_count++;
            end else begin
               v = expected_vertices.pop_front();
               check_field("out_x", v.x, rsp_tdata[31:0]);
               check_field("out_y", v.y, rsp_tdata[63:32]);
               check_field("out_z", v.z, rsp_tdata[95:64]);
               check_field("out_w", v.w, rsp_tdata[127:96]);
               check_field("saturated", 32'(v.sat), 32'(rsp_tuser[0]));
            end
         end
         // command side: update the matrix copy, queue any result
         if (req_tvalid && req_tready) begin
            op  = req_tuser;
            idx = req_tdata[3:0];
            val = req_tdata[35:4];
            x   = req_tdata[67:36];
            y   = req_tdata[99:68];
            z   = req_tdata[131:100];
            w   = req_tdata[163:132];
            case (op)
               CMD_LOAD: model_matrix[idx] = val;
               CMD_VECTOR, CMD_POINT: begin
                  flag = 1'b0;
                  for (int r = 0; r < 4; r++) begin
                     s = row_sum(r, x, y, z);
                     if (op == CMD_VECTOR) s += fx_product(model_matrix[12 + r], w);
                     else s += longint'(model_matrix[12 + r]);
                     c = clip_word(s);
                     flag |= c[32];
                     row_out[r] = c[31:0];
                  end
                  // point: row 3 still counts toward the flag, but w reads zero
                  if (op == CMD_POINT) row_out[3] = '0;
                  v.x = row_out[0];
                  v.y = row_out[1];
                  v.z = row_out[2];
                  v.w = row_out[3];
                  v.sat = flag;
                  expected_vertices.push_back(v);
               end
               CMD_TRANSLATE: begin
                  for (int r = 0; r < 4; r++) begin
                     c = clip_word(row_sum(r, x, y, z) + longint'(model_matrix[12 + r]));
                     model_matrix[12 + r] = c[31:0];
                  end
               end
               CMD_SCALE: begin
                  for (int r = 0; r < 4; r++) begin
                     c = clip_word(fx_product(model_matrix[r], x));
                     model_matrix[r] = c[31:0];
                     c = clip_word(fx_product(model_matrix[4 + r], y));
                     model_matrix[4 + r] = c[31:0];
                     c = clip_word(fx_product(model_matrix[8 + r], z));
                     model_matrix[8 + r] = c[31:0];
                  end
               end
               default: ;   // unused codes change nothing
            endcase
         end
      end
      pending = expected_vertices.size();
   end

endmodule

// ----- verif/affine_matrix_transform_engine_test.sv -----
// Testbench top for the affine matrix transform engine: clock, reset, command stimulus,
// result back-pressure and the verdict. Depends on afmt_pkg, the engine RTL and
// affine_matrix_transform_checker.
module affine_matrix_transform_engine_test;
   timeunit 1ns;
   timeprecision 1ps;
   import afmt_pkg::*;

   localparam logic [2:0] FIRST_UNUSED_CMD = 3'd5;
   localparam logic [2:0] LAST_UNUSED_CMD  = 3'd7;
   localparam int         RANDOM_WORDS     = 1330;
   localparam int         PHASES           = 4;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [167:0] req_tdata  = '0;   // elem_index, elem_value, vec_x, vec_y, vec_z, vec_w
   logic [2:0]   req_tuser  = '0;   // cmd
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;         // out_x, out_y, out_z, out_w
   logic [0:0]   rsp_tuser;         // saturated
   int           fail_count;
   int           pending;
   int           idle_pct   = 0;
   int           stall_pct  = 0;

   always #2 clock = ~clock;

   affine_matrix_transform_engine DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   affine_matrix_transform_checker check (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .fail_count(fail_count), .pending(pending)
   );

   // Result side back-pressure
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // Offer one command word, with random idle cycles ahead of it
   task automatic send_word(input logic [2:0] op, input logic [3:0] idx,
                            input logic [31:0] val, input logic [31:0] x,
                            input logic [31:0] y, input logic [31:0] z,
                            input logic [31:0] w);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'b0, w, z, y, x, val, idx};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Mostly modest Q16.16 values, with full-range words and edge values mixed in
   function automatic logic [31:0] random_value();
      int pick;
      pick = $urandom_range(99);
      if (pick < 40) return 32'($urandom_range(1 << 19)) - 32'(1 << 18);
      if (pick < 55) return 32'($urandom_range(1 << 25)) - 32'(1 << 24);
      if (pick < 65) begin
         case ($urandom_range(6))
            0: return 32'h00000000;
            1: return 32'h00000001;
            2: return 32'hffffffff;
            3: return 32'h7fffffff;
            4: return 32'h80000000;
            5: return FX_ONE;
            default: return -FX_ONE;
         endcase
      end
      return $urandom();
   endfunction

   // Scale factors mostly near +-1.0 so the matrix neither collapses nor pins
   function automatic logic [31:0] scale_factor();
      logic [31:0] f;
      if ($urandom_range(9) < 3) return random_value();
      f = FX_ONE + 32'($urandom_range(1 << 17)) - 32'(1 << 16);
      return ($urandom_range(3) == 0) ? -f : f;
   endfunction

   task automatic send_random_word(output bit counted);
      int          pick;
      logic [2:0]  op;
      logic [31:0] x, y, z;
      pick = $urandom_range(99);
      if (pick < 30)      op = CMD_LOAD;
      else if (pick < 55) op = CMD_VECTOR;
      else if (pick < 75) op = CMD_POINT;
      else if (pick < 85) op = CMD_TRANSLATE;
      else if (pick < 95) op = CMD_SCALE;
      else op = 3'($urandom_range(32'(FIRST_UNUSED_CMD), 32'(LAST_UNUSED_CMD)));
      if (op == CMD_SCALE) begin
         x = scale_factor();
         y = scale_factor();
         z = scale_factor();
      end else begin
         x = random_value();
         y = random_value();
         z = random_value();
      end
      send_word(op, 4'($urandom_range(15)), random_value(), x, y, z, random_value());
      counted = (op <= CMD_SCALE);
   endtask

   initial begin
      int sent;
      bit counted;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // cleared matrix maps everything to the origin
      send_word(CMD_VECTOR, 4'd0, 32'h0, FX_ONE, 32'h7fffffff, 32'h80000000, 32'hffffffff);
      send_word(CMD_POINT, 4'd15, 32'hffffffff, 32'h12345678, 32'hedcba987, 32'h0, 32'h0);
      // identity on the diagonal
      for (int i = 0; i < 4; i++) send_word(CMD_LOAD, 4'(i * 5), FX_ONE, 0, 0, 0, 0);
      send_word(CMD_VECTOR, 4'd0, 32'h0, 32'h7fffffff, 32'h80000000, 32'h0, 32'hffffffff);
      // tiny negative product rounds down, not toward zero
      send_word(CMD_LOAD, 4'd1, 32'h00000001, 0, 0, 0, 0);
      send_word(CMD_VECTOR, 4'd0, 32'h0, 32'hffffffff, FX_ONE, 32'h0, FX_ONE);
      // translation column at both limits, point transform clips high and low
      send_word(CMD_LOAD, 4'd12, 32'h7fffffff, 0, 0, 0, 0);
      send_word(CMD_LOAD, 4'd13, 32'h80000000, 0, 0, 0, 0);
      send_word(CMD_POINT, 4'd0, 32'h0, 32'h7fffffff, 32'h80000000, FX_ONE, FX_ONE);
      // translate drives column 3 further into clipping
      send_word(CMD_TRANSLATE, 4'd0, 32'h0, 32'h00020000, 32'hfffd0000, 32'h00008000,
                $urandom());
      send_word(CMD_VECTOR, 4'd0, 32'h0, FX_ONE, FX_ONE, FX_ONE, FX_ONE);
      // scale by the extremes, then again so stored elements clip
      send_word(CMD_SCALE, 4'd0, 32'h0, 32'h7fffffff, 32'h80000000, FX_ONE, 32'h0);
      send_word(CMD_SCALE, 4'd0, 32'h0, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h0);
      send_word(CMD_VECTOR, 4'd0, 32'h0, FX_ONE, FX_ONE, FX_ONE, FX_ONE);
      // unused command codes must leave the matrix alone
      for (int op = FIRST_UNUSED_CMD; op <= LAST_UNUSED_CMD; op++)
         send_word(3'(op), 4'($urandom_range(15)), $urandom(), $urandom(), $urandom(),
                   $urandom(), $urandom());
      send_word(CMD_POINT, 4'd0, 32'h0, FX_ONE, FX_ONE, FX_ONE, 32'hffffffff);
      // most negative element times most negative w overflows the product sum
      send_word(CMD_LOAD, 4'd15, 32'h80000000, 0, 0, 0, 0);
      send_word(CMD_VECTOR, 4'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h80000000);
      send_word(CMD_LOAD, 4'd0, 32'h7fffffff, 0, 0, 0, 0);

      // random phases: free flow, sender gaps, receiver stalls, both
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 49; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 49; end
            default: begin idle_pct = 13; stall_pct = 13; end
         endcase
         sent = 0;
         while (sent < RANDOM_WORDS / PHASES) begin
            send_random_word(counted);
            if (counted) sent++;
         end
         // hold the sender until every queued result is back
         req_tvalid <= 1'b0;
         @(negedge clock);
         while (pending != 0) @(negedge clock);
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end

      // allow for a matrix update still in the sum stage
      repeat (8) @(posedge clock);
      if (fail_count == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/afmt_pkg.sv
rtl/core/afmt_lane.sv
rtl/core/afmt_merge.sv
rtl/core/affine_matrix_transform_engine.sv
verif/affine_matrix_transform_checker.sv
verif/affine_matrix_transform_engine_test.sv
